// ----- rtl/sep2d_pkg.sv -----
// Shared constants, types and arithmetic helpers of the separable 2-D convolution block.
package sep2d_pkg;

  localparam int MaxTaps      = 8;
  localparam int MaxWidth     = 1024;
  localparam int Channels     = 3;
  localparam int CoefFracBits = 12;
  localparam int MaxOut       = 4;
  localparam int StoreRows    = MaxTaps - 1;
  localparam int ColW         = $clog2(MaxWidth);
  localparam int RowW         = 13;
  localparam int BankW        = $clog2(StoreRows);
  localparam int TapW         = 16;
  localparam int ProdW        = 25;
  localparam int SumW         = 28;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 64;

  typedef logic [Channels-1:0][7:0]     pixel_t;
  typedef logic [MaxTaps-1:0][TapW-1:0] taps_t;
  typedef pixel_t [StoreRows-1:0]       bank_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TAP_COUNT  = 3'd0,
    REG_COL_LOW    = 3'd1,
    REG_COL_HIGH   = 3'd2,
    REG_ROW_LOW    = 3'd3,
    REG_ROW_HIGH   = 3'd4,
    REG_IMG_WIDTH  = 3'd5,
    REG_IMG_HEIGHT = 3'd6
  } reg_idx_e;

  typedef struct packed {
    pixel_t pix;
    logic   eor;
    logic   eof;
    logic   last;
  } result_t;

  function automatic logic signed [ProdW-1:0] mul_term(input logic [7:0] v,
                                                       input logic [TapW-1:0] coef);
    logic signed [ProdW-1:0] a;
    logic signed [ProdW-1:0] b;
    a = {{(ProdW-8){1'b0}}, v};
    b = {{(ProdW-TapW){coef[TapW-1]}}, coef};
    return a * b;
  endfunction

  function automatic logic [7:0] to_pixel(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] sh;
    sh = s >>> CoefFracBits;
    if (s < 0) return 8'd0;
    if (sh > 255) return 8'hFF;
    return sh[7:0];
  endfunction

endpackage

// ----- rtl/sep2d_if.sv -----
// Valid/ready channel interfaces for pixel input, filtered output and register writes.
interface sep2d_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] pixel_ch0;
  logic [7:0] pixel_ch1;
  logic [7:0] pixel_ch2;
  modport source (output valid, op, pixel_ch0, pixel_ch1, pixel_ch2, input ready);
  modport sink   (input valid, op, pixel_ch0, pixel_ch1, pixel_ch2, output ready);
endinterface

interface sep2d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_ch0;
  logic [7:0] out_ch1;
  logic [7:0] out_ch2;
  logic       end_of_row;
  logic       end_of_frame;
  logic       last_of_burst;
  modport source (output valid, out_ch0, out_ch1, out_ch2, end_of_row, end_of_frame,
                  last_of_burst, input ready);
  modport sink   (input valid, out_ch0, out_ch1, out_ch2, end_of_row, end_of_frame,
                  last_of_burst, output ready);
endinterface

interface sep2d_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sep2d_line_store.sv -----
// Line store: one bank per held row, all banks read at one column, one bank written.
module sep2d_line_store
  import sep2d_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [BankW-1:0] wbank_i,
  input  logic [ColW-1:0]  addr_i,
  input  pixel_t           wdata_i,
  input  logic             re_i,
  output bank_data_t       rdata_o
);

  for (genvar b = 0; b < StoreRows; b++) begin : g_bank
    pixel_t mem [MaxWidth];
    pixel_t rd_q;

    always_ff @(posedge clk_i) begin
      if (re_i) begin
        rd_q <= mem[addr_i];
      end
      if (we_i && wbank_i == BankW'(b)) begin
        mem[addr_i] <= wdata_i;
      end
    end

    assign rdata_o[b] = rd_q;
  end

endmodule

// ----- rtl/separable_2d_convolution.sv -----
// Top level of the separable 2-D convolution block: counters, vertical and horizontal passes.
// Pixels enter in raster order at one per clock unless input stalls. The vertical pass runs
// in the cycle after a pixel is taken, from seven line-store banks read at the pixel's column;
// the horizontal pass then forms one output pixel per clock from an eight-entry window while
// the output accepts. A non-final column yields at most one result, so the block sustains one
// pixel per cycle while the output accepts; at the last column of a row up to tap_count-offset
// results are formed, one per clock, and input stalls while they are issued. At most four
// results count toward one input word; a fifth waits and is delivered with the next word,
// which then stalls input further. After the frame the host sends pad words for the rows below
// it (offset rows for odd tap_count, offset+1 for even). No clearing pass follows reset.
module separable_2d_convolution
  import sep2d_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sep2d_in_if.sink    in_i,
  sep2d_out_if.source out_o,
  sep2d_cfg_if.sink   cfg_i
);

  logic [3:0]  tap_count_q;
  taps_t       col_taps_q;
  taps_t       row_taps_q;
  logic [10:0] width_q;
  logic [11:0] height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= 4'd3;
      col_taps_q  <= '0;
      row_taps_q  <= '0;
      width_q     <= 11'd640;
      height_q    <= 12'd480;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_TAP_COUNT:  tap_count_q <= cfg_i.data[3:0];
        REG_COL_LOW:    col_taps_q[3:0] <= cfg_i.data;
        REG_COL_HIGH:   col_taps_q[7:4] <= cfg_i.data;
        REG_ROW_LOW:    row_taps_q[3:0] <= cfg_i.data;
        REG_ROW_HIGH:   row_taps_q[7:4] <= cfg_i.data;
        REG_IMG_WIDTH:  width_q <= cfg_i.data[10:0];
        REG_IMG_HEIGHT: height_q <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end

  logic [3:0]      taps_eff;
  logic [2:0]      off;
  logic [2:0]      la;
  logic [ColW-1:0] wlast;
  logic [11:0]     h_eff;
  logic [RowW-1:0] row_end;

  always_comb begin
    if (tap_count_q == 4'd0) taps_eff = 4'd1;
    else if (tap_count_q > 4'(MaxTaps)) taps_eff = 4'(MaxTaps);
    else taps_eff = tap_count_q;
    off = 3'((taps_eff - 4'd1) >> 1);
    la  = 3'(taps_eff - 4'd1 - {1'b0, off});
    if (width_q == 11'd0) wlast = '0;
    else if (width_q > 11'(MaxWidth)) wlast = ColW'(MaxWidth - 1);
    else wlast = ColW'(width_q - 11'd1);
    h_eff   = (height_q == 12'd0) ? 12'd1 : height_q;
    row_end = RowW'(h_eff) + RowW'(la) - RowW'(1);
  end

  // input side: position, zero fill, line store write
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [BankW-1:0] rmod_q, rmod_d;
  logic [ColW-1:0]  x;
  logic             last_col;
  logic             in_zero;
  pixel_t           cur;
  logic             in_acc;
  logic             s1_go;
  logic             s1_valid_q;
  bank_data_t       bank_rd;

  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    x        = (col_q > wlast) ? wlast : col_q;
    last_col = (x == wlast);
    in_zero  = in_i.op || (row_q >= RowW'(h_eff));
    cur      = in_zero ? '0 : {in_i.pixel_ch2, in_i.pixel_ch1, in_i.pixel_ch0};
    col_d    = col_q;
    row_d    = row_q;
    rmod_d   = rmod_q;
    if (last_col) begin
      col_d = '0;
      if (row_q >= row_end) begin
        row_d  = '0;
        rmod_d = '0;
      end else begin
        row_d  = row_q + RowW'(1);
        rmod_d = (rmod_q == BankW'(StoreRows - 1)) ? '0 : rmod_q + BankW'(1);
      end
    end else begin
      col_d = x + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rmod_q <= '0;
    end else if (in_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      rmod_q <= rmod_d;
    end
  end

  sep2d_line_store u_line_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .wbank_i (rmod_q),
    .addr_i  (x),
    .wdata_i (cur),
    .re_i    (in_acc),
    .rdata_o (bank_rd)
  );

  // vertical stage
  pixel_t           s1_cur_q;
  logic [RowW-1:0]  s1_row_q;
  logic [BankW-1:0] s1_rmod_q;
  logic             s1_last_q;
  logic [2:0]       s1_xm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cur_q  <= cur;
      s1_row_q  <= row_q;
      s1_rmod_q <= rmod_q;
      s1_last_q <= last_col;
      s1_xm_q   <= (x > ColW'(7)) ? 3'd7 : x[2:0];
    end
  end

  pixel_t     vres;
  logic       s1_active;
  logic [2:0] n_new;
  logic [2:0] d0;
  logic [2:0] xm_la;
  logic       s1_ylast;

  always_comb begin
    logic signed [SumW-1:0] sum;
    logic [2:0]             k;
    logic [3:0]             bk;
    logic [7:0]             v;
    vres = '0;
    for (int c = 0; c < Channels; c++) begin
      sum = '0;
      for (int i = 0; i < MaxTaps; i++) begin
        k  = 3'(taps_eff - 4'd1 - 4'(i));
        bk = {1'b0, s1_rmod_q} + 4'(StoreRows) - {1'b0, k};
        if (bk >= 4'(StoreRows)) bk = bk - 4'(StoreRows);
        v = (k == 3'd0) ? s1_cur_q[c] : bank_rd[bk[BankW-1:0]][c];
        if (4'(i) < taps_eff && RowW'(k) <= s1_row_q &&
            (s1_row_q - RowW'(k)) < RowW'(h_eff)) begin
          sum = sum + SumW'(mul_term(v, col_taps_q[i]));
        end
      end
      vres[c] = to_pixel(sum);
    end
    s1_active = s1_row_q >= RowW'(la);
    xm_la     = (s1_xm_q < la) ? s1_xm_q : la;
    s1_ylast  = s1_row_q == row_end;
    if (!s1_active) begin
      n_new = 3'd0;
      d0    = la;
    end else if (s1_last_q) begin
      n_new = xm_la + 3'd1;
      d0    = xm_la;
    end else begin
      n_new = (s1_xm_q >= la) ? 3'd1 : 3'd0;
      d0    = la;
    end
  end

  // horizontal stage: window and burst sequencer
  pixel_t     win_q [MaxTaps];
  logic [2:0] left_q;
  logic [2:0] j_q;
  logic       p_q;
  logic [2:0] tot_q;
  logic [2:0] d_q;
  logic       jlast_q;
  logic       jylast_q;
  logic [2:0] jxm_q;
  result_t    hold_q;
  logic       hold_valid_q;
  result_t    out_q;
  logic       out_valid_q;

  logic       out_can;
  logic       issue;
  logic       s2_free;
  logic       from_hold;
  logic       to_hold;
  logic       flag;
  logic [2:0] end_idx;
  logic       p_new;
  result_t    calc;
  result_t    item;

  always_comb begin
    logic signed [SumW-1:0] sum;
    logic [3:0]             base;
    logic [3:0]             idx;
    calc = '0;
    base = {1'b0, d_q} + {1'b0, off};
    for (int c = 0; c < Channels; c++) begin
      sum = '0;
      for (int i = 0; i < MaxTaps; i++) begin
        idx = base - 4'(i);
        if (4'(i) < taps_eff && base >= 4'(i) && idx <= {1'b0, jxm_q}) begin
          sum = sum + SumW'(mul_term(win_q[idx[2:0]][c], row_taps_q[i]));
        end
      end
      calc.pix[c] = to_pixel(sum);
    end
    calc.eor  = jlast_q && (d_q == 3'd0);
    calc.eof  = calc.eor && jylast_q;
    calc.last = 1'b0;

    out_can   = !out_valid_q || out_o.ready;
    issue     = (left_q != 3'd0) && out_can;
    s2_free   = (left_q == 3'd0) || (left_q == 3'd1 && out_can);
    s1_go     = s1_valid_q && s2_free;
    from_hold = p_q && (j_q == 3'd0);
    to_hold   = issue && !from_hold && (j_q == 3'(MaxOut));
    end_idx   = ((tot_q > 3'(MaxOut)) ? 3'(MaxOut) : tot_q) - 3'd1;
    flag      = (j_q == end_idx);
    item      = from_hold ? hold_q : calc;
    item.last = flag;
    p_new     = (hold_valid_q && !(issue && from_hold)) || to_hold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < MaxTaps; t++) win_q[t] <= '0;
      left_q       <= '0;
      j_q          <= '0;
      p_q          <= 1'b0;
      tot_q        <= '0;
      d_q          <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s1_go && s1_active) begin
        for (int t = MaxTaps - 1; t > 0; t--) win_q[t] <= win_q[t-1];
        win_q[0] <= vres;
      end
      if (s1_go) begin
        left_q <= 3'(p_new) + n_new;
        tot_q  <= 3'(p_new) + n_new;
        j_q    <= '0;
        p_q    <= p_new;
        d_q    <= d0;
      end else if (issue) begin
        left_q <= left_q - 3'd1;
        j_q    <= j_q + 3'd1;
        if (!from_hold && d_q != 3'd0) d_q <= d_q - 3'd1;
      end
      if (to_hold) begin
        hold_valid_q <= 1'b1;
      end else if (issue && from_hold) begin
        hold_valid_q <= 1'b0;
      end
      if (issue && !to_hold) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      jlast_q  <= s1_last_q;
      jylast_q <= s1_ylast;
      jxm_q    <= s1_xm_q;
    end
    if (to_hold) hold_q <= calc;
    if (issue && !to_hold) out_q <= item;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_ch0       = out_q.pix[0];
  assign out_o.out_ch1       = out_q.pix[1];
  assign out_o.out_ch2       = out_q.pix[2];
  assign out_o.end_of_row    = out_q.eor;
  assign out_o.end_of_frame  = out_q.eof;
  assign out_o.last_of_burst = out_q.last;

  a_hold_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    to_hold |-> !hold_valid_q)
    else $error("second carried word while one is held");

  a_hold_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && from_hold) |-> hold_valid_q)
    else $error("carried word sent from an empty hold register");

  a_burst_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= 3'(MaxOut + 1))
    else $error("burst longer than the window allows");

  a_stage_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted word lost before the vertical pass");

endmodule
